// ----- rtl/sctc_pkg.sv -----
// Package for the sample count to timestamp converter.
// Holds the command codes, register indexes and fixed widths. No dependencies.
package sctc_pkg;

    localparam int CMD_W    = 3;
    localparam int TIME_W   = 64;
    localparam int COUNT_W  = 32;
    localparam int FREQ_W   = 20;
    localparam int SPF_W    = 16;
    localparam int NUM_W    = 52;  // count * 1e6 + freq/2 stays below 2^52
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [FREQ_W-1:0] US_PER_SECOND = FREQ_W'(1000000);

    localparam logic [CMD_W-1:0] CMD_SET     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONVERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FRAME   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLING_FREQ     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_FRAME = 2'd1;

endpackage

// ----- rtl/sctc_scale.sv -----
// Scaling unit: round(count * 1e6 / freq) by one multiply then a
// bit-serial restoring divide, one quotient bit per cycle. Uses sctc_pkg.
module sctc_scale
    import sctc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COUNT_W-1:0] count,
    input  logic [FREQ_W-1:0]  freq,
    output logic               done,
    output logic [NUM_W-1:0]   quot
);

    localparam int ITER_W = $clog2(NUM_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [FREQ_W-1:0]  rem_reg, rem_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic               done_reg, done_next;

    logic [FREQ_W:0]    rem_shift;
    logic [FREQ_W:0]    rem_diff;
    logic               ge;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign ge        = rem_shift >= {1'b0, freq_reg};
    assign rem_diff  = rem_shift - {1'b0, freq_reg};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        freq_next  = freq_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        iter_next  = iter_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    count_next = count;
                    freq_next  = freq;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // rounding: add half the divisor before the truncating divide
                num_next   = NUM_W'(count_reg) * NUM_W'(US_PER_SECOND)
                           + NUM_W'(freq_reg >> 1);
                rem_next   = '0;
                iter_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = ge ? rem_diff[FREQ_W-1:0] : rem_shift[FREQ_W-1:0];
                num_next  = {num_reg[NUM_W-2:0], ge};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(NUM_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        freq_reg  <= freq_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

// ----- rtl/sample_count_timestamp_converter_top.sv -----
// Top level of the sample count to timestamp converter.
// Depends on sctc_pkg and sctc_scale.

// Set and add commands give no result. Convert, peek and frame duration go
// through these steps from accept to result: load the scaling unit, the
// count times 1e6 multiply, the bit-serial divide by the sampling rate, the
// base add (convert and peek only) and the load of the output register. With
// a zero sampling rate those commands skip the scaling unit. The input is not
// ready while a command is in the scaling unit or its result waits for the
// output register; a result waiting in the output register does not block new
// commands until the next result needs that register.
module sample_count_timestamp_converter_top
    import sctc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // command stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TIME_W-1:0]     s_tdata,   // [63:0] operand
    input  logic [CMD_W-1:0]      s_tuser,   // [2:0] cmd
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TIME_W-1:0]     m_tdata    // [63:0] time_us
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic [SPF_W-1:0]   spf_reg, spf_next;
    logic [TIME_W-1:0]  base_reg, base_next;
    logic [COUNT_W-1:0] accum_reg, accum_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [TIME_W-1:0]  res_reg, res_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TIME_W-1:0]  m_tdata_reg, m_tdata_next;

    logic               in_fire;
    logic               cfg_fire;
    logic               scale_start;
    logic [COUNT_W-1:0] scale_count;
    logic               scale_done;
    logic [NUM_W-1:0]   scale_quot;
    logic [TIME_W-1:0]  quot_ext;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign quot_ext  = TIME_W'(scale_quot);

    assign scale_start = in_fire && (freq_reg != '0)
                      && (s_tuser == CMD_CONVERT || s_tuser == CMD_PEEK
                          || s_tuser == CMD_FRAME);
    assign scale_count = (s_tuser == CMD_FRAME) ? COUNT_W'(spf_reg) : accum_reg;

    sctc_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .count (scale_count),
        .freq  (freq_reg),
        .done  (scale_done),
        .quot  (scale_quot)
    );

    always_comb
    begin
        state_next    = state_reg;
        freq_next     = freq_reg;
        spf_next      = spf_reg;
        base_next     = base_reg;
        accum_next    = accum_reg;
        cmd_next      = cmd_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (cfg_fire)
        begin
            if (cfg_index == CFG_SAMPLING_FREQ)
            begin
                if (cfg_data[FREQ_W-1:0] != '0)
                    freq_next = cfg_data[FREQ_W-1:0];
            end
            else if (cfg_index == CFG_SAMPLES_PER_FRAME)
            begin
                spf_next = cfg_data[SPF_W-1:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next = s_tuser;
                    case (s_tuser)
                        CMD_SET:
                        begin
                            base_next  = s_tdata;
                            accum_next = '0;
                        end
                        CMD_ADD:
                        begin
                            accum_next = accum_reg + s_tdata[COUNT_W-1:0];
                        end
                        CMD_CONVERT, CMD_PEEK, CMD_FRAME:
                        begin
                            if (freq_reg != '0)
                            begin
                                state_next = S_CALC;
                            end
                            else
                            begin
                                // no rate yet: base passes through, duration is zero
                                res_next   = (s_tuser == CMD_FRAME) ? '0 : base_reg;
                                if (s_tuser == CMD_CONVERT)
                                    accum_next = '0;
                                state_next = S_OUT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CALC:
            begin
                if (scale_done)
                begin
                    if (cmd_reg == CMD_FRAME)
                    begin
                        res_next = quot_ext;
                    end
                    else
                    begin
                        res_next = base_reg + quot_ext;
                        if (cmd_reg == CMD_CONVERT)
                        begin
                            base_next  = base_reg + quot_ext;
                            accum_next = '0;
                        end
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            freq_reg     <= '0;
            spf_reg      <= '0;
            base_reg     <= '0;
            accum_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            freq_reg     <= freq_next;
            spf_reg      <= spf_next;
            base_reg     <= base_next;
            accum_reg    <= accum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sample_count_timestamp_converter_top.
// Predicts each returned timestamp in a small scoreboard class; needs sctc_pkg and the RTL.
module tb;
    import sctc_pkg::*;

    localparam int DRAIN_CYCLES = 64;   // long enough for a trailing command to pass the scaling path
    localparam int PHASE_ITEMS  = 250;
    localparam int MAX_PRINTS   = 40;

    localparam logic [CMD_W-1:0]     CMD_SPARE_LO = CMD_FRAME + 1'b1;
    localparam logic [CMD_W-1:0]     CMD_SPARE_HI = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A  = CFG_SAMPLES_PER_FRAME + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B  = CFG_SPARE_A + 1'b1;

    localparam logic [TIME_W-1:0] TS_MAX = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic [TIME_W-1:0] TS_MIN = {1'b1, {(TIME_W-1){1'b0}}};

    class timestamp_scoreboard;
        logic [FREQ_W-1:0]  rate;
        logic [SPF_W-1:0]   frame_len;
        logic [TIME_W-1:0]  ts_base;
        logic [COUNT_W-1:0] sample_sum;
        logic [TIME_W-1:0]  expected_times[$];
        int                 errors;

        function new();
            rate       = '0;
            frame_len  = '0;
            ts_base    = '0;
            sample_sum = '0;
            errors     = 0;
        endfunction

        // rounded count * 1e6 / rate; rate must be nonzero
        function logic [TIME_W-1:0] samples_to_us(logic [COUNT_W-1:0] count);
            logic [TIME_W-1:0] num;
            num = TIME_W'(count) * TIME_W'(1000000) + TIME_W'(rate >> 1);
            return num / TIME_W'(rate);
        endfunction

        function logic [TIME_W-1:0] now_us();
            if (rate == '0)
                return ts_base;
            return ts_base + samples_to_us(sample_sum);
        endfunction

        function void note_register_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SAMPLING_FREQ)
            begin
                if (data[FREQ_W-1:0] != '0)
                    rate = data[FREQ_W-1:0];
            end
            else if (idx == CFG_SAMPLES_PER_FRAME)
                frame_len = data[SPF_W-1:0];
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] operand);
            logic [TIME_W-1:0] t;
            case (cmd)
                CMD_SET:
                begin
                    ts_base    = operand;
                    sample_sum = '0;
                end
                CMD_ADD:
                    sample_sum = sample_sum + operand[COUNT_W-1:0];
                CMD_CONVERT:
                begin
                    t          = now_us();
                    ts_base    = t;
                    sample_sum = '0;
                    expected_times.push_back(t);
                end
                CMD_PEEK:
                    expected_times.push_back(now_us());
                CMD_FRAME:
                    expected_times.push_back((rate == '0) ? '0 :
                                             samples_to_us(COUNT_W'(frame_len)));
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_times.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t ns: %s", $time, msg);
        endtask

        task check_time(logic [TIME_W-1:0] got);
            logic [TIME_W-1:0] want;
            if (expected_times.size() == 0)
                report($sformatf("unexpected result time_us=%h", got));
            else
            begin
                want = expected_times.pop_front();
                if (got !== want)
                    report($sformatf("time_us got %h expected %h", got, want));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TIME_W-1:0]     s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TIME_W-1:0]     m_tdata;

    int src_idle;
    int snk_idle;
    timestamp_scoreboard sb;

    int rate_plan[6]  = '{48000, 1, 1048575, 44100, 8000, 96000};
    int frame_plan[6] = '{1024, 65535, 0, 1152, 1, 4096};

    sample_count_timestamp_converter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: check every transaction, stall at random
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_time(m_tdata);
        m_tready <= ($urandom_range(99) >= snk_idle);
    end

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.note_register_write(idx, data);
    endtask

    task automatic set_rates(input int freq, input int spf);
        write_reg(CFG_SAMPLING_FREQ, {12'($urandom), FREQ_W'(freq)});
        write_reg(CFG_SAMPLES_PER_FRAME, {16'($urandom), SPF_W'(spf)});
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] operand);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= operand;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_command(cmd, operand);
    endtask

    // all results in, then let a trailing command leave the scaling unit
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly set/add/convert, also peek/frame, with random content, some spare codes as noise
    task automatic random_item();
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] op;
        pick = $urandom_range(99);
        op   = {$urandom, $urandom};
        if (pick < 15)
        begin
            cmd = CMD_SET;
            case ($urandom_range(9))
                0: op = TS_MAX - $urandom_range(100000);
                1: op = TS_MIN;
                2: op = '1 - $urandom_range(1000000);
                3: op = TIME_W'($urandom_range(1000000));
                default: ;
            endcase
        end
        else if (pick < 50)
        begin
            cmd = CMD_ADD;
            case ($urandom_range(4))
                0: op[COUNT_W-1:0] = $urandom_range(2000);
                1: op[COUNT_W-1:0] = $urandom_range(65535);
                2: op[COUNT_W-1:0] = '1 - $urandom_range(1000);
                default: ;
            endcase
        end
        else if (pick < 65)
            cmd = CMD_CONVERT;
        else if (pick < 80)
            cmd = CMD_PEEK;
        else if (pick < 92)
            cmd = CMD_FRAME;
        else
            cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        send_cmd(cmd, op);
    endtask

    initial
    begin
        sb        = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        src_idle  = 0;
        snk_idle  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rate still zero after reset: base comes back as is, frame gives 0
        send_cmd(CMD_PEEK, {$urandom, $urandom});
        send_cmd(CMD_FRAME, {$urandom, $urandom});
        send_cmd(CMD_SET, TS_MAX);
        send_cmd(CMD_ADD, '1);
        send_cmd(CMD_CONVERT, {$urandom, $urandom});
        send_cmd(CMD_SET, TS_MIN);
        send_cmd(CMD_PEEK, '0);
        send_cmd(CMD_SET, '1);
        send_cmd(CMD_ADD, 64'd5);
        send_cmd(CMD_SPARE_LO, '1);
        send_cmd(CMD_SPARE_LO + 1'b1, '1);
        send_cmd(CMD_SPARE_HI, '1);
        send_cmd(CMD_PEEK, '0);
        wait_idle();

        // 1 Hz: largest quotients, count wrap and timestamp wrap
        set_rates(1, 65535);
        cfg_valid <= 1'b0;
        send_cmd(CMD_FRAME, '0);
        send_cmd(CMD_ADD, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_cmd(CMD_ADD, 64'd2);
        send_cmd(CMD_PEEK, '0);
        send_cmd(CMD_CONVERT, '0);
        send_cmd(CMD_SET, '0);
        send_cmd(CMD_ADD, 64'hFFFF_FFFF);
        send_cmd(CMD_CONVERT, '0);
        wait_idle();

        // top rate with empty frames; a one-sample count rounds up to 1 us
        set_rates(1048575, 0);
        cfg_valid <= 1'b0;
        send_cmd(CMD_FRAME, '0);
        send_cmd(CMD_ADD, 64'd1);
        send_cmd(CMD_PEEK, '0);
        send_cmd(CMD_CONVERT, '0);

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            set_rates(rate_plan[ph], frame_plan[ph]);
            if (ph == 2)
            begin
                // zero rate write must leave the rate alone; spare indexes do nothing
                write_reg(CFG_SAMPLING_FREQ, {12'($urandom), {FREQ_W{1'b0}}});
                write_reg(CFG_SPARE_A, $urandom);
                write_reg(CFG_SPARE_B, $urandom);
            end
            cfg_valid <= 1'b0;
            src_idle = (ph < 2) ? 6 : (ph < 4) ? 49 : 0;
            snk_idle = (ph < 2) ? 49 : (ph < 4) ? 6 : 0;
            repeat (PHASE_ITEMS) random_item();
        end
        wait_idle();

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sctc_pkg.sv
rtl/sctc_scale.sv
rtl/sample_count_timestamp_converter_top.sv
sim/tb.sv
